// ----- hdl/cdq_pkg.sv -----
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared constants, codes, types and index helper functions of the circular deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic exec;
    logic load_pop;
  } cmd_t;

  typedef struct packed {
    logic need_read;
  } dp_status_t;

  function automatic idx_t idx_up(idx_t i);
    idx_t r;
    if (i == idx_t'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + idx_t'(1);
    end
    return r;
  endfunction

  function automatic idx_t idx_dn(idx_t i);
    idx_t r;
    if (i == '0) begin
      r = idx_t'(DEPTH - 1);
    end else begin
      r = i - idx_t'(1);
    end
    return r;
  endfunction

endpackage

// ----- hdl/circular_deque.sv -----
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of DEPTH words in a circular store with one result
// per operation.
// ----------------------------------------------------------------------------
// Each input transaction carries one operation and returns one result
// transaction with the popped word, a status code, the occupancy and the
// empty and full flags. One operation is handled at a time: a push or a
// rejected pop shows its result in the cycle after acceptance, a successful
// pop only after a further read state, because the store has a registered
// read port. The next input is taken in the cycle after the result
// transaction.
module circular_deque import cdq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // op[1:0], push_value[33:2], zero padding[39:34]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // pop_value[31:0], status[33:32], occupancy[38:34], is_empty[39],
  // is_full[40], zero padding[47:41]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  cmd_t              cmd;
  dp_status_t        dp_status;
  logic signed [31:0] pop_value;
  logic [1:0]        status;
  logic [4:0]        occupancy;
  logic              is_empty, is_full;
  logic              unused_pad;

  assign unused_pad = ^in_tdata[IN_TDATA_W-1:34];

  cdq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .dp_status  (dp_status),
    .cmd        (cmd)
  );

  cdq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .dp_status  (dp_status),
    .op         (in_tdata[1:0]),
    .push_value (in_tdata[33:2]),
    .pop_value  (pop_value),
    .status     (status),
    .occupancy  (occupancy),
    .is_empty   (is_empty),
    .is_full    (is_full)
  );

  assign out_tdata = {7'd0, is_full, is_empty, occupancy, status, pop_value};

endmodule

// ----- hdl/cdq_ram.sv -----
// ----------------------------------------------------------------------------
// cdq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/cdq_ctrl.sv -----
// ----------------------------------------------------------------------------
// cdq_ctrl
// Controller of the circular deque: sequences accept, read and result.
// ----------------------------------------------------------------------------
module cdq_ctrl import cdq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  dp_status_t dp_status,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_tready    = 1'b0;
    out_tvalid   = 1'b0;
    cmd.exec     = 1'b0;
    cmd.load_pop = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.exec  = 1'b1;
          state_nxt = dp_status.need_read ? ST_READ : ST_OUT;
        end
      end
      ST_READ: begin
        cmd.load_pop = 1'b1;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and result accepted in the same cycle");

  a_read_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> (state_r == ST_OUT))
    else $error("read wait not followed by result");

  a_exec_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> !cmd.exec)
    else $error("two transactions executed back to back");

endmodule

// ----- hdl/cdq_dp.sv -----
// ----------------------------------------------------------------------------
// cdq_dp
// Datapath of the circular deque: pointers, count, store and result registers.
// ----------------------------------------------------------------------------
module cdq_dp import cdq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output dp_status_t        dp_status,
  input  logic [1:0]        op,
  input  logic signed [31:0] push_value,
  output logic signed [31:0] pop_value,
  output logic [1:0]        status,
  output logic [4:0]        occupancy,
  output logic              is_empty,
  output logic              is_full
);

  idx_t  head_r, head_nxt;
  idx_t  tail_r, tail_nxt;
  cnt_t  count_r, count_nxt;
  stat_t stat_r, stat_nxt;
  cnt_t  occ_r;
  logic  empty_r, full_r;
  logic signed [31:0] pop_r;

  logic  is_push, is_front, full, empty;
  logic  we;
  idx_t  waddr, raddr;
  word_t wdata, rdata;
  logic signed [63:0] wide_in, wide_out;

  assign is_push  = (op == OP_PUSH_FRONT) || (op == OP_PUSH_REAR);
  assign is_front = (op == OP_PUSH_FRONT) || (op == OP_POP_FRONT);
  assign full     = (count_r == cnt_t'(DEPTH));
  assign empty    = (count_r == '0);

  assign wide_in  = 64'(push_value);
  assign wdata    = word_t'(wide_in);
  assign raddr    = is_front ? head_r : tail_r;

  assign dp_status.need_read = !is_push && !empty;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    stat_nxt  = STAT_DONE;
    we        = 1'b0;
    waddr     = '0;
    if (is_push) begin
      if (full) begin
        stat_nxt = STAT_OVERFLOW;
      end else begin
        we        = 1'b1;
        count_nxt = count_r + cnt_t'(1);
        if (empty) begin
          head_nxt = '0;
          tail_nxt = '0;
          waddr    = '0;
        end else if (is_front) begin
          head_nxt = idx_dn(head_r);
          waddr    = head_nxt;
        end else begin
          tail_nxt = idx_up(tail_r);
          waddr    = tail_nxt;
        end
      end
    end else begin
      if (empty) begin
        stat_nxt = STAT_UNDERFLOW;
      end else begin
        count_nxt = count_r - cnt_t'(1);
        if (count_r == cnt_t'(1)) begin
          head_nxt = '0;
          tail_nxt = '0;
        end else if (is_front) begin
          head_nxt = idx_up(head_r);
        end else begin
          tail_nxt = idx_dn(tail_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  assign wide_out = 64'(signed'(rdata));

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      stat_r  <= stat_nxt;
      occ_r   <= count_nxt;
      empty_r <= (count_nxt == '0);
      full_r  <= (count_nxt == cnt_t'(DEPTH));
      pop_r   <= '0;
    end else if (cmd.load_pop) begin
      pop_r   <= 32'(wide_out);
    end
  end

  cdq_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we && cmd.exec),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign pop_value = pop_r;
  assign status    = stat_r;
  assign occupancy = 5'(occ_r);
  assign is_empty  = empty_r;
  assign is_full   = full_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(DEPTH))
    else $error("held count beyond depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == '0 && tail_r == '0))
    else $error("pointers not at zero while empty");

  a_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && full) |-> !(we && cmd.exec))
    else $error("store written while full");

endmodule

// ----- tb/tb_circular_deque.sv -----
// ----------------------------------------------------------------------------
// tb_circular_deque
// Self-checking testbench of the circular deque.
// ----------------------------------------------------------------------------
// A short directed sequence covers underflow at both ends, pushes into an
// empty deque, removal of the last word and the extreme word values. Random
// bursts then follow, some biased toward pushes so that the deque fills and
// overflows, some toward pops so that it drains and underflows. The bursts
// run under several idle and stall patterns on the two streams. A scoreboard
// keeps its own copy of the deque, predicts one result per accepted
// transaction and compares every result transaction field by field.
// ----------------------------------------------------------------------------
module tb_circular_deque import cdq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    word_t pop_value;
    stat_t status;
    cnt_t  occupancy;
    logic  is_empty;
    logic  is_full;
  } reply_t;

  class deque_scoreboard;
    word_t       slots[DEPTH];
    idx_t        front_idx;
    idx_t        rear_idx;
    cnt_t        fill;
    reply_t      pending_replies[$];
    int unsigned mismatches;

    function new();
      front_idx  = '0;
      rear_idx   = '0;
      fill       = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction

    function void apply_op(op_t op, word_t value);
      reply_t r;
      idx_t   slot;
      r.pop_value = '0;
      r.status    = STAT_DONE;
      if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR) begin
        if (fill >= cnt_t'(DEPTH)) begin
          r.status = STAT_OVERFLOW;
        end else begin
          if (fill == '0) begin
            front_idx = '0;
            rear_idx  = '0;
            slot      = '0;
          end else if (op == OP_PUSH_FRONT) begin
            front_idx = (front_idx == '0) ? idx_t'(DEPTH - 1) : front_idx - idx_t'(1);
            slot      = front_idx;
          end else begin
            rear_idx = (rear_idx == idx_t'(DEPTH - 1)) ? '0 : rear_idx + idx_t'(1);
            slot     = rear_idx;
          end
          slots[slot] = value;
          fill        = fill + cnt_t'(1);
        end
      end else begin
        if (fill == '0) begin
          r.status = STAT_UNDERFLOW;
        end else begin
          r.pop_value = (op == OP_POP_FRONT) ? slots[front_idx] : slots[rear_idx];
          fill        = fill - cnt_t'(1);
          if (fill == '0) begin
            front_idx = '0;
            rear_idx  = '0;
          end else if (op == OP_POP_FRONT) begin
            front_idx = (front_idx == idx_t'(DEPTH - 1)) ? '0 : front_idx + idx_t'(1);
          end else begin
            rear_idx = (rear_idx == '0) ? idx_t'(DEPTH - 1) : rear_idx - idx_t'(1);
          end
        end
      end
      r.occupancy = fill;
      r.is_empty  = (fill == '0);
      r.is_full   = (fill >= cnt_t'(DEPTH));
      pending_replies.push_back(r);
    endfunction

    function void note_failure(string what, logic [63:0] exp_v, logic [63:0] act_v);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%t mismatch on %s: expected %h, actual %h", $realtime, what, exp_v, act_v);
      end
    endfunction

    function void check_reply(logic [OUT_TDATA_W-1:0] d);
      reply_t e;
      if (pending_replies.size() == 0) begin
        note_failure("unexpected result transaction", '0, 64'(d));
        return;
      end
      e = pending_replies.pop_front();
      if (d[31:0] !== e.pop_value) note_failure("pop_value", 64'(e.pop_value), 64'(d[31:0]));
      if (d[33:32] !== e.status) note_failure("status", 64'(e.status), 64'(d[33:32]));
      if (d[38:34] !== e.occupancy) note_failure("occupancy", 64'(e.occupancy), 64'(d[38:34]));
      if (d[39] !== e.is_empty) note_failure("is_empty", 64'(e.is_empty), 64'(d[39]));
      if (d[40] !== e.is_full) note_failure("is_full", 64'(e.is_full), 64'(d[40]));
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int              sender_idle_pct    = 0;
  int              receiver_stall_pct = 0;
  deque_scoreboard sb                 = new();

  circular_deque uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_reply(out_tdata);
    end
    out_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  task automatic send_op(op_t op, word_t value);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - 34){1'b0}}, value, op};
    do @(posedge clk); while (!in_tready);
    sb.apply_op(op, value);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic op_t pick_op(int push_pct);
    if ($urandom_range(99) < push_pct) begin
      return $urandom_range(1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
    end
    return $urandom_range(1) ? OP_POP_REAR : OP_POP_FRONT;
  endfunction

  function automatic word_t pick_value();
    case ($urandom_range(15))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic run_random(int count);
    int sent;
    int burst;
    int push_pct;
    int mode;
    sent = 0;
    while (sent < count) begin
      mode     = $urandom_range(2);
      burst    = $urandom_range(10, 60);
      push_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
      for (int i = 0; i < burst && sent < count; i++) begin
        send_op(pick_op(push_pct), pick_value());
        sent++;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_op(OP_POP_FRONT, 32'h1234_5678);
    send_op(OP_POP_REAR, 32'hffff_ffff);
    send_op(OP_PUSH_FRONT, 32'h8000_0000);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_PUSH_REAR, 32'h7fff_ffff);
    send_op(OP_POP_REAR, '0);
    send_op(OP_PUSH_REAR, '0);
    send_op(OP_PUSH_FRONT, 32'hffff_ffff);
    send_op(OP_PUSH_REAR, 32'h0000_0001);
    send_op(OP_PUSH_FRONT, 32'h8000_0000);
    send_op(OP_POP_FRONT, 32'h5555_5555);
    send_op(OP_POP_REAR, 32'haaaa_aaaa);
    send_op(OP_POP_REAR, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_REAR, '0);
    wait_drained();

    run_random(460);
    wait_drained();

    sender_idle_pct = 49;
    run_random(460);
    wait_drained();

    sender_idle_pct    = 0;
    receiver_stall_pct = 49;
    run_random(460);
    wait_drained();

    sender_idle_pct    = 31;
    receiver_stall_pct = 31;
    run_random(460);
    wait_drained();

    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/cdq_pkg.sv
hdl/cdq_ram.sv
hdl/cdq_ctrl.sv
hdl/cdq_dp.sv
hdl/circular_deque.sv
tb/tb_circular_deque.sv
